FILE: rtl/core/hpa_pkg.sv
// Package for the task set hyperperiod analyzer.
// Holds widths, the sequencer state type, payload structs and unit request/response structs.
// No dependencies.
package hpa_pkg;

  localparam int TIME_W   = 32;                       // width of the time fields
  localparam int FRAC_W   = 16;                       // utilization fraction bits
  localparam int UTIL_W   = 32;                       // utilization sum width
  localparam int DIVD_W   = TIME_W + FRAC_W;          // divider dividend width
  localparam int DCNT_W   = $clog2(DIVD_W + 1);       // divider step counter
  localparam int SHIFT_W  = $clog2(TIME_W);           // common power-of-two count in GCD
  localparam int PROD_W   = 2 * TIME_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVQ,
    ST_LCM,
    ST_UTIL,
    ST_DIVU,
    ST_DONE
  } hpa_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] task_offset;
    logic [TIME_W-1:0] task_deadline;
    logic [TIME_W-1:0] task_period;
    logic [TIME_W-1:0] task_wcet;
    logic              last_task;
  } task_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] hyperperiod;
    logic              hyperperiod_overflow;
    logic              all_synchronous;
    logic              implicit_deadlines;
    logic              constrained_deadlines;
    logic [UTIL_W-1:0] utilization_q16;
    logic              utilization_saturated;
    logic              set_done;
  } task_out_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } gcd_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] g;
  } gcd_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/core/hpa_gcd.sv
// Binary GCD unit: one subtract or shift step per cycle.
// Depends on hpa_pkg. Both operands must be nonzero.
module hpa_gcd (
  input  logic            clk,
  input  logic            rst,
  input  hpa_pkg::gcd_req_t req,
  output hpa_pkg::gcd_rsp_t rsp
);
  import hpa_pkg::*;

  logic [TIME_W-1:0]  u;
  logic [TIME_W-1:0]  v;
  logic [SHIFT_W-1:0] k;
  logic               busy;
  logic               done;
  logic [TIME_W-1:0]  g;
  logic [TIME_W-1:0]  u_minus_v;
  logic [TIME_W-1:0]  v_minus_u;

  assign u_minus_v = u - v;
  assign v_minus_u = v - u;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        u    <= req.a;
        v    <= req.b;
        k    <= '0;
      end else if (busy) begin
        if (u == v) begin
          busy <= 1'b0;
          done <= 1'b1;
          g    <= u << k;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u > v) begin
          u <= u_minus_v >> 1;
        end else begin
          v <= v_minus_u >> 1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.g    = g;

endmodule

FILE: rtl/core/hpa_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on hpa_pkg. Divisor must be nonzero.
module hpa_div (
  input  logic            clk,
  input  logic            rst,
  input  hpa_pkg::div_req_t req,
  output hpa_pkg::div_rsp_t rsp
);
  import hpa_pkg::*;

  logic [TIME_W-1:0] rem;
  logic [DIVD_W-1:0] quo;
  logic [TIME_W-1:0] dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [TIME_W:0]   shifted;
  logic              fits;
  logic [TIME_W:0]   diff;

  assign shifted = {rem, quo[DIVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= DCNT_W'(DIVD_W);
      end else if (busy) begin
        // remainder stays below the divisor, so the top bit drops
        rem <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
        quo <= {quo[DIVD_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: rtl/core/task_set_hyperperiod_analyzer_unit.sv
// Task set hyperperiod analyzer: running LCM, deadline/offset flags, Q16.16 utilization.
// One request at a time: the result register loads once the request has passed the binary GCD,
// up to two passes of the shared divider and a free output register.
// Throughput: the next request is taken the cycle after the result register loads.
// Reset (rst, synchronous) empties the output register and returns the set state to start.
// Depends on hpa_pkg, hpa_gcd, hpa_div.
module task_set_hyperperiod_analyzer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hpa_pkg::task_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hpa_pkg::task_out_t out_data
);
  import hpa_pkg::*;

  hpa_state_t state, state_next;

  // set state
  logic [TIME_W-1:0] running_lcm;
  logic              lcm_overflowed;
  logic [TIME_W-1:0] first_offset;
  logic              have_first;
  logic              sync_flag;
  logic              implicit_flag;
  logic              constrained_flag;
  logic [UTIL_W-1:0] util_sum;
  logic              util_clipped;

  // current request
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] wcet;
  logic              last;
  logic [PROD_W-1:0] prod;

  gcd_req_t gcd_req;
  gcd_rsp_t gcd_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              accept;
  logic              out_free;
  logic [TIME_W-1:0] lcm_base;
  logic              lcm_skip;
  logic [UTIL_W:0]   util_total;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign lcm_base = (running_lcm == '0) ? TIME_W'(1) : running_lcm;
  assign lcm_skip = lcm_overflowed || (in_data.task_period == '0);
  // quotient fits UTIL_W+1 bits only if upper bits are zero; otherwise clip anyway
  assign util_total = {1'b0, util_sum} + (UTIL_W+1)'(div_rsp.quotient);

  hpa_gcd u_gcd (
    .clk (clk),
    .rst (rst),
    .req (gcd_req),
    .rsp (gcd_rsp)
  );

  hpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    gcd_req.start    = 1'b0;
    gcd_req.a        = lcm_base;
    gcd_req.b        = in_data.task_period;
    div_req.start    = 1'b0;
    div_req.dividend = {wcet, FRAC_W'(0)};
    div_req.divisor  = period;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (lcm_skip) begin
            state_next = ST_UTIL;
          end else begin
            gcd_req.start = 1'b1;
            state_next    = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (gcd_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'(lcm_base);
          div_req.divisor  = gcd_rsp.g;
          state_next       = ST_DIVQ;
        end
      end
      ST_DIVQ: begin
        if (div_rsp.done) begin
          state_next = ST_LCM;
        end
      end
      ST_LCM: begin
        state_next = ST_UTIL;
      end
      ST_UTIL: begin
        if (util_clipped || period == '0) begin
          state_next = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = ST_DIVU;
        end
      end
      ST_DIVU: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // quotient of lcm/g times the period; product registered before the overflow check
  always_ff @(posedge clk) begin
    if (state == ST_DIVQ && div_rsp.done) begin
      prod <= PROD_W'(div_rsp.quotient[TIME_W-1:0]) * PROD_W'(period);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      period <= in_data.task_period;
      wcet   <= in_data.task_wcet;
      last   <= in_data.last_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_lcm      <= TIME_W'(1);
      lcm_overflowed   <= 1'b0;
      first_offset     <= '0;
      have_first       <= 1'b0;
      sync_flag        <= 1'b1;
      implicit_flag    <= 1'b1;
      constrained_flag <= 1'b1;
      util_sum         <= '0;
      util_clipped     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // a drained result is replaced directly when the next one is ready
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        if (!have_first) begin
          first_offset <= in_data.task_offset;
          have_first   <= 1'b1;
        end else if (in_data.task_offset != first_offset) begin
          sync_flag <= 1'b0;
        end
        if (in_data.task_deadline != in_data.task_period) begin
          implicit_flag <= 1'b0;
        end
        if (in_data.task_deadline > in_data.task_period) begin
          constrained_flag <= 1'b0;
        end
      end

      if (state == ST_LCM) begin
        if (prod[PROD_W-1:TIME_W] != '0) begin
          lcm_overflowed <= 1'b1;
        end else begin
          running_lcm <= prod[TIME_W-1:0];
        end
      end

      // zero period with nonzero wcet saturates the sum
      if (state == ST_UTIL && !util_clipped && period == '0 && wcet != '0) begin
        util_sum     <= '1;
        util_clipped <= 1'b1;
      end

      if (state == ST_DIVU && div_rsp.done) begin
        if (div_rsp.quotient[DIVD_W-1:UTIL_W] != '0 || util_total[UTIL_W]) begin
          util_sum     <= '1;
          util_clipped <= 1'b1;
        end else begin
          util_sum <= util_total[UTIL_W-1:0];
        end
      end

      if (state == ST_DONE && out_free) begin
        out_valid                      <= 1'b1;
        out_data.hyperperiod           <= running_lcm;
        out_data.hyperperiod_overflow  <= lcm_overflowed;
        out_data.all_synchronous       <= sync_flag;
        out_data.implicit_deadlines    <= implicit_flag;
        out_data.constrained_deadlines <= constrained_flag;
        out_data.utilization_q16       <= util_sum;
        out_data.utilization_saturated <= util_clipped;
        out_data.set_done              <= last;
        if (last) begin
          running_lcm      <= TIME_W'(1);
          lcm_overflowed   <= 1'b0;
          first_offset     <= '0;
          have_first       <= 1'b0;
          sync_flag        <= 1'b1;
          implicit_flag    <= 1'b1;
          constrained_flag <= 1'b1;
          util_sum         <= '0;
          util_clipped     <= 1'b0;
        end
      end
    end
  end

endmodule
